### hdl/ivs_pkg.sv
`timescale 1ns / 1ps
package ivs_pkg;

   localparam int KIND_BITS = 3;
   localparam int IDX_BITS  = 21;
   localparam int AMT_BITS  = 16;
   localparam int CAP_BITS  = 9;
   localparam int STAT_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_PUSH   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_POP    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_GET    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_SET    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_ROTATE = 3'd4;

   localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [STAT_BITS-1:0] STAT_BAD_INDEX = 2'd3;

   localparam logic signed [IDX_BITS-1:0] REGISTRY_INDEX = -21'sd1001000;

   typedef logic [2:0] cell_op_type;

   localparam cell_op_type OP_HOLD = 3'd0;
   localparam cell_op_type OP_PUSH = 3'd1;
   localparam cell_op_type OP_POP  = 3'd2;
   localparam cell_op_type OP_SET  = 3'd3;
   localparam cell_op_type OP_ROT  = 3'd4;
   localparam cell_op_type OP_READ = 3'd5;

endpackage

### hdl/ivs_cell.sv
`timescale 1ns / 1ps
module ivs_cell #(
   parameter int WORD_BITS = 64,
   parameter int IDXW      = 8
) (
   input  logic                   clock,
   input  ivs_pkg::cell_op_type   op,
   input  logic [IDXW-1:0]        my_idx,
   input  logic [IDXW-1:0]        sel_idx,
   input  logic [WORD_BITS-1:0]   wdata,
   input  logic [WORD_BITS-1:0]   head_data,
   input  logic [WORD_BITS-1:0]   up_data,
   input  logic [WORD_BITS-1:0]   down_data,
   input  logic [WORD_BITS-1:0]   up_rd,
   output logic [WORD_BITS-1:0]   data_out,
   output logic [WORD_BITS-1:0]   rd_out
);

   logic [WORD_BITS-1:0] data_ff, data_in;
   logic [WORD_BITS-1:0] rd_ff, rd_in;

   always_comb begin
      data_in = data_ff;
      rd_in   = rd_ff;
      case (op)
         ivs_pkg::OP_PUSH: data_in = down_data;
         ivs_pkg::OP_POP:  data_in = up_data;
         ivs_pkg::OP_SET: begin
            if (my_idx == sel_idx) data_in = wdata;
         end
         ivs_pkg::OP_ROT: begin
            if (my_idx < sel_idx) data_in = up_data;
            else if (my_idx == sel_idx) data_in = head_data;
         end
         ivs_pkg::OP_READ: rd_in = (my_idx == sel_idx) ? data_ff : up_rd;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data_out = data_ff;
   assign rd_out   = rd_ff;

endmodule

### hdl/ivs_mod.sv
`timescale 1ns / 1ps
module ivs_mod #(
   parameter int DEN_BITS = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ivs_pkg::AMT_BITS-1:0]     num,
   input  logic [DEN_BITS-1:0]              den,
   output logic                             done,
   output logic [DEN_BITS-1:0]              rem
);

   localparam int CNTW = $clog2(ivs_pkg::AMT_BITS);

   logic [ivs_pkg::AMT_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0]          rem_ff, rem_in;
   logic [DEN_BITS-1:0]          den_ff, den_in;
   logic [CNTW-1:0]              cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [DEN_BITS:0]            trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[ivs_pkg::AMT_BITS-1]};
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CNTW'(ivs_pkg::AMT_BITS - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[ivs_pkg::AMT_BITS-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) rem_in = DEN_BITS'(trial - {1'b0, den_ff});
         else rem_in = trial[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### hdl/indexed_value_stack_with_rotate.sv
`timescale 1ns / 1ps
// Channel  Ports                             Payload (low bit up)
// req      req_tvalid/tready/tdata/tuser     tuser: kind; tdata: slot_index, rotate_amount,
//                                            write_value
// rsp      rsp_tvalid/tready/tdata           tdata: read_value, stack_top, status
// csr      csr_valid/ready/data              capacity
//
// Push, pop, set and errors: the result is set in S_EXEC and sent from S_DONE. Get of
// cell j (0 = top): the read chain walks one cell per cycle to the head, then S_RDOUT
// takes it. Rotate: the remainder unit reduces the amount modulo the segment length,
// then one cell-chain step per place turned. Reset is synchronous; slot contents are
// not cleared. A new item is taken while the previous result still waits on rsp_tready.
module indexed_value_stack_with_rotate #(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,   // slot_index, rotate_amount, write_value
   input  logic [2:0]    req_tuser,   // kind
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [79:0]   rsp_tdata,   // read_value, stack_top, status
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [8:0]    csr_data
);

   localparam int IDXW = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_RDOUT = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ROT   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 kind_ff, kind_in;
   logic signed [20:0]         idx_ff, idx_in;
   logic [15:0]                amt_ff, amt_in;
   logic [WORD_BITS-1:0]       wval_ff, wval_in;
   logic [CW-1:0]              top_ff, top_in;
   logic [WORD_BITS-1:0]       reg_ff, reg_in;
   logic [8:0]                 cap_ff, cap_in;
   logic [IDXW-1:0]            tgt_ff, tgt_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]       rval_ff, rval_in;
   logic [1:0]                 stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [79:0]                rsp_data_ff, rsp_data_in;

   ivs_pkg::cell_op_type       op;
   logic [IDXW-1:0]            sel;
   logic                       div_start, div_done;
   logic [CW-1:0]              div_rem;
   logic [CW-1:0]              seg_len;
   logic [15:0]                amt_abs;

   logic signed [23:0]         idx_ext, top_ext, pos_s;
   logic                       is_reg, pos_ok, full;
   logic [IDXW-1:0]            jcell;
   logic [31:0]                top32, cap32;

   logic [WORD_BITS-1:0]       data_w [DEPTH];
   logic [WORD_BITS-1:0]       rd_w   [DEPTH];

   always_comb begin
      idx_ext = {{3{idx_ff[20]}}, idx_ff};
      top_ext = $signed(24'(top_ff));
      pos_s   = idx_ff[20] ? idx_ext + top_ext + 24'sd1 : idx_ext;
      is_reg  = (idx_ff == ivs_pkg::REGISTRY_INDEX);
      pos_ok  = !is_reg && (pos_s > 24'sd0) && (pos_s <= top_ext);
      jcell   = IDXW'(top_ff - pos_s[CW-1:0]);
      top32   = 32'(top_ff);
      cap32   = 32'(cap_ff);
      full    = (top32 >= cap32) || (top32 >= 32'(DEPTH));
      seg_len = CW'(tgt_ff) + CW'(1);
      amt_abs = amt_ff[15] ? 16'(-amt_ff) : amt_ff;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      amt_in       = amt_ff;
      wval_in      = wval_ff;
      top_in       = top_ff;
      reg_in       = reg_ff;
      cap_in       = cap_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      rval_in      = rval_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      op           = ivs_pkg::OP_HOLD;
      sel          = tgt_ff;
      div_start    = 1'b0;

      if (csr_valid) cap_in = csr_data;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               idx_in   = req_tdata[20:0];
               amt_in   = req_tdata[36:21];
               wval_in  = req_tdata[WORD_BITS+36:37];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rval_in  = '0;
            stat_in  = ivs_pkg::STAT_OK;
            state_in = S_DONE;
            sel      = jcell;
            tgt_in   = jcell;
            case (kind_ff)
               ivs_pkg::KIND_PUSH: begin
                  if (full) stat_in = ivs_pkg::STAT_OVERFLOW;
                  else begin
                     op     = ivs_pkg::OP_PUSH;
                     top_in = top_ff + CW'(1);
                  end
               end
               ivs_pkg::KIND_POP: begin
                  if (top_ff == '0) stat_in = ivs_pkg::STAT_UNDERFLOW;
                  else begin
                     rval_in = data_w[0];
                     op      = ivs_pkg::OP_POP;
                     top_in  = top_ff - CW'(1);
                  end
               end
               ivs_pkg::KIND_GET: begin
                  if (is_reg) rval_in = reg_ff;
                  else if (!pos_ok) stat_in = ivs_pkg::STAT_BAD_INDEX;
                  else begin
                     cnt_in   = CW'(jcell);
                     state_in = S_READ;
                  end
               end
               ivs_pkg::KIND_SET: begin
                  if (is_reg) reg_in = wval_ff;
                  else if (!pos_ok) stat_in = ivs_pkg::STAT_BAD_INDEX;
                  else op = ivs_pkg::OP_SET;
               end
               ivs_pkg::KIND_ROTATE: begin
                  if (!pos_ok) stat_in = ivs_pkg::STAT_BAD_INDEX;
                  else state_in = S_DIV;
               end
               default: ;
            endcase
         end
         S_READ: begin
            op     = ivs_pkg::OP_READ;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) state_in = S_RDOUT;
         end
         S_RDOUT: begin
            rval_in  = rd_w[0];
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               cnt_in   = (amt_ff[15] && div_rem != '0) ? seg_len - div_rem : div_rem;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            if (cnt_ff == '0) state_in = S_DONE;
            else begin
               op     = ivs_pkg::OP_ROT;
               cnt_in = cnt_ff - CW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, stat_ff, 9'(top_ff), 64'(rval_ff)};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (state_ff == S_EXEC && kind_ff == ivs_pkg::KIND_ROTATE && pos_ok) div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         reg_ff       <= '0;
         cap_ff       <= 9'd256;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         reg_ff       <= reg_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      amt_ff      <= amt_in;
      wval_ff     <= wval_in;
      tgt_ff      <= tgt_in;
      rval_ff     <= rval_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

   ivs_mod #(.DEN_BITS(CW)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (amt_abs),
      .den   (CW'(jcell) + CW'(1)),
      .done  (div_done),
      .rem   (div_rem)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] up_d, down_d, up_r;
      if (g == DEPTH - 1) begin : g_last
         assign up_d = '0;
         assign up_r = '0;
      end else begin : g_mid
         assign up_d = data_w[g+1];
         assign up_r = rd_w[g+1];
      end
      if (g == 0) begin : g_head
         assign down_d = wval_ff;
      end else begin : g_body
         assign down_d = data_w[g-1];
      end
      ivs_cell #(.WORD_BITS(WORD_BITS), .IDXW(IDXW)) u_cell (
         .clock     (clock),
         .op        (op),
         .my_idx    (IDXW'(g)),
         .sel_idx   (sel),
         .wdata     (wval_ff),
         .head_data (data_w[0]),
         .up_data   (up_d),
         .down_data (down_d),
         .up_rd     (up_r),
         .data_out  (data_w[g]),
         .rd_out    (rd_w[g])
      );
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
